// ----- design/secd_pkg.sv -----
// Package for the STX/ETX CRC-16 deframer.
// It holds the input, result, classified-item and configuration types and the shared codes.
// Every module of the block takes these types from here.
`timescale 1ns / 1ps
`default_nettype none

package secd_pkg;

    localparam logic [2:0] R_START  = 3'd0;
    localparam logic [2:0] R_END    = 3'd1;
    localparam logic [2:0] R_MAXPAY = 3'd2;
    localparam logic [2:0] R_STALL  = 3'd3;
    localparam logic [2:0] R_POLY   = 3'd4;
    localparam logic [2:0] R_INIT   = 3'd5;
    localparam logic [2:0] R_JSON   = 3'd6;
    localparam logic [2:0] R_BINARY = 3'd7;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [2:0] V_JSON    = 3'd0;
    localparam logic [2:0] V_BINARY  = 3'd1;
    localparam logic [2:0] V_UNKNOWN = 3'd2;
    localparam logic [2:0] V_CRC     = 3'd3;
    localparam logic [2:0] V_LENGTH  = 3'd4;
    localparam logic [2:0] V_NOEND   = 3'd5;
    localparam logic [2:0] V_STALL   = 3'd6;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] data_byte;
        logic       first_flag;
        logic [2:0] verdict;
    } t_out;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [15:0] len_limit;
        logic [15:0] stall_ticks;
        logic [15:0] crc_poly;
        logic [15:0] crc_init;
        logic [7:0]  json_type;
        logic [7:0]  binary_type;
    } t_cfg;

    typedef struct packed {
        logic       is_tick;
        logic [7:0] rx_byte;
        logic       is_start;
        logic       is_end;
        logic       is_json;
        logic       is_binary;
    } t_evt;

endpackage

`default_nettype wire

// ----- design/secd_front.sv -----
// Front end of the deframer: accepts input items and classifies them.
// Each byte is compared against the framing and type bytes before queuing.
// Depends on secd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module secd_front (
    input  wire  secd_pkg::t_in  i_item,
    input  wire  secd_pkg::t_cfg i_cfg,
    output secd_pkg::t_evt       o_evt
);

    always_comb begin
        o_evt.is_tick   = i_item.opcode;
        o_evt.rx_byte   = i_item.rx_byte;
        o_evt.is_start  = (i_item.rx_byte == i_cfg.start_byte);
        o_evt.is_end    = (i_item.rx_byte == i_cfg.end_byte);
        o_evt.is_json   = (i_item.rx_byte == i_cfg.json_type);
        o_evt.is_binary = (i_item.rx_byte == i_cfg.binary_type);
    end

endmodule

`default_nettype wire

// ----- design/secd_fifo.sv -----
// Two-entry queue of classified items between the front and back ends.
// Depends on secd_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module secd_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire  secd_pkg::t_evt i_data,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_valid,
    output secd_pkg::t_evt       o_data
);

    secd_pkg::t_evt r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/secd_back.sv -----
// Back end of the deframer: frame parser, CRC-16 and the result register.
// It consumes classified items from the queue whenever the result slot is free.
// Depends on secd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module secd_back #(
    parameter int MAX_FRAME = 65535
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire  secd_pkg::t_cfg i_cfg,
    input  wire                  i_evt_valid,
    input  wire  secd_pkg::t_evt i_evt,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output secd_pkg::t_out       o_out
);

    localparam int          CntW   = $clog2(MAX_FRAME + 1);
    localparam logic [15:0] MaxLen = 16'(MAX_FRAME);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CRC,
        PH_END
    } t_phase;

    t_phase         r_phase;
    logic [1:0]     r_len_cnt;
    logic [15:0]    r_len;
    logic           r_len_big;
    logic [CntW-1:0] r_pay_cnt;
    logic [15:0]    r_crc;
    logic [15:0]    r_rx_crc;
    logic           r_crc_hi;
    logic           r_type_json;
    logic           r_type_bin;
    logic [15:0]    r_sil;
    logic           r_out_valid;
    secd_pkg::t_out r_out;

    logic [15:0]     n_sil;
    logic [15:0]     n_crc;
    logic [CntW-1:0] n_pay_cnt;
    logic            w_len_bad;

    function automatic logic [15:0] crc_byte(
        input logic [15:0] crc,
        input logic [7:0]  b,
        input logic [15:0] poly
    );
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

    function automatic secd_pkg::t_out verdict_out(input logic [2:0] v);
        return '{secd_pkg::KIND_VERDICT, 8'd0, 1'b0, v};
    endfunction

    assign o_pop       = i_evt_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign n_sil     = (r_sil == 16'hFFFF) ? r_sil : r_sil + 16'd1;
    assign n_crc     = crc_byte(r_crc, i_evt.rx_byte, i_cfg.crc_poly);
    assign n_pay_cnt = r_pay_cnt + CntW'(1);
    assign w_len_bad = r_len_big || (i_evt.rx_byte != 8'd0) || (r_len == 16'd0)
                       || (r_len > i_cfg.len_limit) || (r_len > MaxLen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_len_cnt   <= 2'd0;
            r_len       <= 16'd0;
            r_len_big   <= 1'b0;
            r_crc_hi    <= 1'b0;
            r_sil       <= 16'd0;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b0;
            if (i_evt.is_tick) begin
                if (r_phase != PH_IDLE) begin
                    if (n_sil > i_cfg.stall_ticks) begin
                        r_out_valid <= 1'b1;
                        r_out       <= verdict_out(secd_pkg::V_STALL);
                        r_phase     <= PH_IDLE;
                        r_sil       <= 16'd0;
                        r_len_cnt   <= 2'd0;
                        r_crc_hi    <= 1'b0;
                    end else begin
                        r_sil <= n_sil;
                    end
                end
            end else begin
                r_sil <= 16'd0;
                unique case (r_phase)
                    PH_IDLE: begin
                        if (i_evt.is_start) begin
                            r_phase   <= PH_LENGTH;
                            r_len_cnt <= 2'd0;
                            r_len     <= 16'd0;
                            r_len_big <= 1'b0;
                        end
                    end
                    PH_LENGTH: begin
                        r_len_cnt <= r_len_cnt + 2'd1;
                        unique case (r_len_cnt)
                            2'd0: r_len[7:0]  <= i_evt.rx_byte;
                            2'd1: r_len[15:8] <= i_evt.rx_byte;
                            2'd2: r_len_big   <= (i_evt.rx_byte != 8'd0);
                            2'd3: begin
                                if (w_len_bad) begin
                                    r_out_valid <= 1'b1;
                                    r_out       <= verdict_out(secd_pkg::V_LENGTH);
                                    r_phase     <= PH_IDLE;
                                end else begin
                                    r_pay_cnt <= '0;
                                    r_crc     <= i_cfg.crc_init;
                                    r_phase   <= PH_PAYLOAD;
                                end
                            end
                        endcase
                    end
                    PH_PAYLOAD: begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{secd_pkg::KIND_DATA, i_evt.rx_byte,
                                         (r_pay_cnt == '0), 3'd0};
                        if (r_pay_cnt == '0) begin
                            r_type_json <= i_evt.is_json;
                            r_type_bin  <= i_evt.is_binary;
                        end
                        r_crc     <= n_crc;
                        r_pay_cnt <= n_pay_cnt;
                        if (16'(n_pay_cnt) == r_len) begin
                            r_phase  <= PH_CRC;
                            r_crc_hi <= 1'b0;
                        end
                    end
                    PH_CRC: begin
                        if (!r_crc_hi) begin
                            r_rx_crc[7:0] <= i_evt.rx_byte;
                            r_crc_hi      <= 1'b1;
                        end else begin
                            r_rx_crc[15:8] <= i_evt.rx_byte;
                            r_crc_hi       <= 1'b0;
                            r_phase        <= PH_END;
                        end
                    end
                    PH_END: begin
                        r_out_valid <= 1'b1;
                        r_phase     <= PH_IDLE;
                        r_len_cnt   <= 2'd0;
                        priority if (!i_evt.is_end) begin
                            r_out <= verdict_out(secd_pkg::V_NOEND);
                        end else if (r_rx_crc != r_crc) begin
                            r_out <= verdict_out(secd_pkg::V_CRC);
                        end else if (r_type_json) begin
                            r_out <= verdict_out(secd_pkg::V_JSON);
                        end else if (r_type_bin) begin
                            r_out <= verdict_out(secd_pkg::V_BINARY);
                        end else begin
                            r_out <= verdict_out(secd_pkg::V_UNKNOWN);
                        end
                    end
                    default: begin
                        r_phase <= PH_IDLE;
                    end
                endcase
            end
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- design/stx_etx_crc16_deframer.sv -----
// Top level of the STX/ETX length-prefixed CRC-16 byte stream deframer.
// Holds the configuration registers and joins front end, queue and back end.
// Depends on secd_pkg, secd_front, secd_fifo and secd_back.
//
//   Port group   Direction  Handshake                  Content
//   input        in         i_in_valid / o_in_stall    opcode, rx_byte
//   output       out        o_out_valid / i_out_stall  out_kind, data_byte, first_flag, verdict
//   config       in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One item is taken per cycle while the queue is not full; an accepted item is written into the queue
// and is parsed into the output register when the back end pops it.
// The parser's combinational byte CRC update and phase logic set that rate.
// Reset is synchronous and returns the parser to hunting for the start byte.
// A stalled result holds in the output register; the two-entry queue absorbs
// items until it fills, and only then is the input stalled.
`timescale 1ns / 1ps
`default_nettype none

module stx_etx_crc16_deframer #(
    parameter int MAX_FRAME = 65535
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire  secd_pkg::t_in  i_in,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output secd_pkg::t_out       o_out,
    input  wire                  i_cfg_we,
    input  wire  [2:0]           i_cfg_idx,
    input  wire  [15:0]          i_cfg_data
);

    secd_pkg::t_cfg r_cfg;
    secd_pkg::t_evt w_evt_in;
    secd_pkg::t_evt w_evt_q;
    logic           w_full;
    logic           w_q_valid;
    logic           w_pop;
    logic           w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte  <= 8'd2;
            r_cfg.end_byte    <= 8'd3;
            r_cfg.len_limit   <= 16'd4096;
            r_cfg.stall_ticks <= 16'd100;
            r_cfg.crc_poly    <= 16'h1021;
            r_cfg.crc_init    <= 16'hFFFF;
            r_cfg.json_type   <= 8'd1;
            r_cfg.binary_type <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                secd_pkg::R_START:  r_cfg.start_byte  <= i_cfg_data[7:0];
                secd_pkg::R_END:    r_cfg.end_byte    <= i_cfg_data[7:0];
                secd_pkg::R_MAXPAY: r_cfg.len_limit   <= i_cfg_data;
                secd_pkg::R_STALL:  r_cfg.stall_ticks <= i_cfg_data;
                secd_pkg::R_POLY:   r_cfg.crc_poly    <= i_cfg_data;
                secd_pkg::R_INIT:   r_cfg.crc_init    <= i_cfg_data;
                secd_pkg::R_JSON:   r_cfg.json_type   <= i_cfg_data[7:0];
                secd_pkg::R_BINARY: r_cfg.binary_type <= i_cfg_data[7:0];
            endcase
        end
    end

    assign o_in_stall = w_full;
    assign w_push     = i_in_valid && !w_full;

    secd_front u_front (
        .i_item (i_in),
        .i_cfg  (r_cfg),
        .o_evt  (w_evt_in)
    );

    secd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_evt_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_evt_q)
    );

    secd_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_evt_valid (w_q_valid),
        .i_evt       (w_evt_q),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
